@@ hw/rtl/mstd_pkg.sv @@
// Shared types and codes for the sync-word TLV deframer.
package mstd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_SYNC_ERR = 2'd2;
  localparam logic [1:0] KIND_OVERSIZE = 2'd3;

  // Route codes
  localparam logic [1:0] ROUTE_FIRST   = 2'd0;
  localparam logic [1:0] ROUTE_SECOND  = 2'd1;
  localparam logic [1:0] ROUTE_UNKNOWN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [1:0] REG_FIRST_TYPE  = 2'd1;
  localparam logic [1:0] REG_SECOND_TYPE = 2'd2;
  localparam logic [1:0] REG_MAX_LEN     = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] SYNC_WORD_RST   = 32'h4142_1356;
  localparam logic [7:0]  FIRST_TYPE_RST  = 8'd1;
  localparam logic [7:0]  SECOND_TYPE_RST = 8'd2;
  localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  route;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } cfg_write_t;

endpackage

@@ hw/rtl/mstd_stream_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
interface mstd_stream_if #(
  parameter type data_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/magic_sync_tlv_deframer_top.sv @@
// Sync-word TLV deframer: parses one received byte per cycle, while the skid stage is empty, into routed results.
// Results are registered: the output register, backed by a skid stage, lets a new byte transfer
// while a finished result still waits downstream; input stalls while the skid stage holds one.
// Reset (rst, synchronous): parser returns to sync gathering, registers take their
// defaults, output and skid stages empty.
module magic_sync_tlv_deframer_top
  import mstd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mstd_stream_if.sink          rx,
  mstd_stream_if.source        result,
  mstd_stream_if.sink          cfg
);

  // Parser phase codes
  localparam logic [2:0] PH_SYNC = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  // Configuration registers
  logic [31:0] sync_word;
  logic [7:0]  first_route_type;
  logic [7:0]  second_route_type;
  logic [15:0] max_payload_len;

  // Parser state
  logic [2:0]  parse_phase, parse_phase_next;
  logic [31:0] sync_shift, sync_shift_next;
  logic [1:0]  header_count, header_count_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] payload_count, payload_count_next;

  // Output and skid stages
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;

  logic        rx_fire, out_fire;
  logic [7:0]  b;
  logic [1:0]  route_cur;
  logic [15:0] count_inc;
  logic        res_valid;
  result_t     res;

  rx_item_t   rx_item;
  cfg_write_t cfg_item;

  assign rx_item  = rx.data;
  assign cfg_item = cfg.data;
  assign b        = rx_item.rx_byte;

  // Config writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word         <= SYNC_WORD_RST;
      first_route_type  <= FIRST_TYPE_RST;
      second_route_type <= SECOND_TYPE_RST;
      max_payload_len   <= MAX_LEN_RST;
    end else if (cfg.valid) begin
      case (cfg_item.reg_index)
        REG_SYNC_WORD:   sync_word         <= cfg_item.wdata;
        REG_FIRST_TYPE:  first_route_type  <= cfg_item.wdata[7:0];
        REG_SECOND_TYPE: second_route_type <= cfg_item.wdata[7:0];
        REG_MAX_LEN:     max_payload_len   <= cfg_item.wdata[15:0];
        default: ;
      endcase
    end
  end

  // Handshakes: input stalls only while the skid stage holds a result
  assign rx.ready     = ~skid_valid;
  assign rx_fire      = rx.valid & ~skid_valid;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign out_fire     = out_valid & result.ready;

  // Route lookup, first destination wins on a tie
  always_comb begin
    if (held_type == first_route_type) begin
      route_cur = ROUTE_FIRST;
    end else if (held_type == second_route_type) begin
      route_cur = ROUTE_SECOND;
    end else begin
      route_cur = ROUTE_UNKNOWN;
    end
  end

  assign count_inc = payload_count + 16'd1;

  // Per-byte parse step
  always_comb begin
    parse_phase_next   = parse_phase;
    sync_shift_next    = sync_shift;
    header_count_next  = header_count;
    held_type_next     = held_type;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.route          = route_cur;
    res.frame_type     = held_type;
    res.payload_byte   = 8'd0;
    res.byte_index     = 16'd0;
    res.last_of_frame  = 1'b1;
    case (parse_phase)
      PH_TYPE: begin
        held_type_next   = b;
        parse_phase_next = PH_LENH;
      end
      PH_LENH: begin
        held_length_next = {b, 8'd0};
        parse_phase_next = PH_LENL;
      end
      PH_LENL: begin
        held_length_next   = {held_length[15:8], b};
        payload_count_next = 16'd0;
        if (held_length_next == 16'd0) begin
          parse_phase_next = PH_SYNC;
          res_valid        = 1'b1;
          res.kind         = KIND_EMPTY;
        end else if (held_length_next > max_payload_len) begin
          parse_phase_next = PH_SKIP;
          res_valid        = 1'b1;
          res.kind         = KIND_OVERSIZE;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = b;
        res.byte_index     = payload_count;
        res.last_of_frame  = (count_inc == held_length);
        payload_count_next = count_inc;
        if (count_inc == held_length) parse_phase_next = PH_SYNC;
      end
      PH_SKIP: begin
        payload_count_next = count_inc;
        if (count_inc == held_length) parse_phase_next = PH_SYNC;
      end
      default: begin
        // Sync gathering; unused phase codes land here too
        parse_phase_next = PH_SYNC;
        sync_shift_next  = {sync_shift[23:0], b};
        if (header_count != 2'd3) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          if (sync_shift_next == sync_word) begin
            parse_phase_next = PH_TYPE;
          end else begin
            res_valid      = 1'b1;
            res.kind       = KIND_SYNC_ERR;
            res.route      = ROUTE_UNKNOWN;
            res.frame_type = 8'd0;
          end
        end
      end
    endcase
  end

  // Parser state update on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_SYNC;
      sync_shift    <= 32'd0;
      header_count  <= 2'd0;
      held_type     <= 8'd0;
      held_length   <= 16'd0;
      payload_count <= 16'd0;
    end else if (rx_fire) begin
      parse_phase   <= parse_phase_next;
      sync_shift    <= sync_shift_next;
      header_count  <= header_count_next;
      held_type     <= held_type_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= rx_fire & res_valid;
      end
    end else if (rx_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the two stages
  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (rx_fire && res_valid) begin
        out_data <= res;
      end
    end else if (rx_fire && res_valid) begin
      skid_data <= res;
    end
  end

endmodule

@@ bench/magic_sync_tlv_deframer_top_test.sv @@
// Self-checking testbench for the sync-word TLV deframer: directed frames, then random traffic.
module magic_sync_tlv_deframer_top_test;
  import mstd_pkg::*;

  // Parser stages of the expected-result model
  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_TYPE   = 3'd1,
    ST_LEN_HI = 3'd2,
    ST_LEN_LO = 3'd3,
    ST_DATA   = 3'd4,
    ST_SKIP   = 3'd5
  } parse_stage_t;

  // Deframer model plus the queue of results still owed by the block
  class deframe_scoreboard;
    logic [31:0]  sync_word;
    logic [7:0]   first_type;
    logic [7:0]   second_type;
    logic [15:0]  max_len;
    parse_stage_t stage;
    logic [31:0]  gathered;
    logic [1:0]   sync_cnt;
    logic [7:0]   cur_type;
    logic [15:0]  cur_len;
    logic [15:0]  count;
    result_t      owed_q[$];
    int           errors;
    int           checked;
    int           kind_seen[4];

    function new();
      sync_word   = SYNC_WORD_RST;
      first_type  = FIRST_TYPE_RST;
      second_type = SECOND_TYPE_RST;
      max_len     = MAX_LEN_RST;
      stage       = ST_HUNT;
      gathered    = '0;
      sync_cnt    = '0;
      cur_type    = '0;
      cur_len     = '0;
      count       = '0;
      errors      = 0;
      checked     = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SYNC_WORD:   sync_word   = value;
        REG_FIRST_TYPE:  first_type  = value[7:0];
        REG_SECOND_TYPE: second_type = value[7:0];
        REG_MAX_LEN:     max_len     = value[15:0];
        default: ;
      endcase
    endfunction

    // First destination wins when both types match
    function logic [1:0] route_for(logic [7:0] t);
      if (t == first_type) return ROUTE_FIRST;
      if (t == second_type) return ROUTE_SECOND;
      return ROUTE_UNKNOWN;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // One line per mismatch
    task report(string msg);
      errors++;
      $display("MISMATCH at result %0d: %s", checked, msg);
    endtask

    // Advance the model by one transferred byte
    function void note_byte(logic [7:0] b);
      result_t     r;
      bit          fire;
      logic [15:0] nxt;
      fire = 1'b0;
      r    = '0;
      nxt  = count + 16'd1;
      case (stage)
        ST_TYPE: begin
          cur_type = b;
          stage    = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          cur_len = {b, 8'h00};
          stage   = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          cur_len[7:0] = b;
          count        = '0;
          if (cur_len == 16'd0) begin
            stage = ST_HUNT;
            fire  = 1'b1;
            r     = '{KIND_EMPTY, route_for(cur_type), cur_type, 8'h00, 16'd0, 1'b1};
          end else if (cur_len > max_len) begin
            stage = ST_SKIP;
            fire  = 1'b1;
            r     = '{KIND_OVERSIZE, route_for(cur_type), cur_type, 8'h00, 16'd0, 1'b1};
          end else begin
            stage = ST_DATA;
          end
        end
        ST_DATA: begin
          fire  = 1'b1;
          r     = '{KIND_PAYLOAD, route_for(cur_type), cur_type, b, count, nxt == cur_len};
          count = nxt;
          if (r.last_of_frame) stage = ST_HUNT;
        end
        ST_SKIP: begin
          count = nxt;
          if (count == cur_len) stage = ST_HUNT;
        end
        default: begin
          // sync gathering in fixed groups of four, no sliding search
          stage    = ST_HUNT;
          gathered = {gathered[23:0], b};
          if (sync_cnt < 2'd3) begin
            sync_cnt++;
          end else begin
            sync_cnt = '0;
            if (gathered == sync_word) begin
              stage = ST_TYPE;
            end else begin
              fire = 1'b1;
              r    = '{KIND_SYNC_ERR, ROUTE_UNKNOWN, 8'h00, 8'h00, 16'd0, 1'b1};
            end
          end
        end
      endcase
      if (fire) owed_q = {owed_q, r};
    endfunction

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d type 0x%0h index %0d",
                         got.kind, got.frame_type, got.byte_index));
        checked++;
        return;
      end
      want = owed_q.pop_front();
      kind_seen[want.kind]++;
      cmp_field("kind", got.kind, want.kind);
      cmp_field("route", got.route, want.route);
      cmp_field("frame_type", got.frame_type, want.frame_type);
      cmp_field("payload_byte", got.payload_byte, want.payload_byte);
      cmp_field("byte_index", got.byte_index, want.byte_index);
      cmp_field("last_of_frame", got.last_of_frame, want.last_of_frame);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 0;
  int   sink_idle = 0;
  int   bytes_sent = 0;
  int   settings_applied = 0;

  deframe_scoreboard sb = new();

  mstd_stream_if #(.data_t(rx_item_t))   rx_ch ();
  mstd_stream_if #(.data_t(result_t))    res_ch ();
  mstd_stream_if #(.data_t(cfg_write_t)) cfg_ch ();

  magic_sync_tlv_deframer_top dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_idle);
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Timeout: %0d results still owed", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One byte transfer; valid stays high for a back-to-back follower
  task automatic send_byte(input logic [7:0] b);
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data  <= '{rx_byte: b};
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sender holds off until every owed result has arrived
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] sw, input logic [7:0] ft, input logic [7:0] st,
                          input logic [15:0] ml);
    cfg_write_t w[4];
    drain_results();
    w[0] = '{REG_SYNC_WORD, sw};
    w[1] = '{REG_FIRST_TYPE, {24'h0, ft}};
    w[2] = '{REG_SECOND_TYPE, {24'h0, st}};
    w[3] = '{REG_MAX_LEN, {16'h0, ml}};
    foreach (w[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= w[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.write_reg(w[i].reg_index, w[i].wdata);
    end
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_header(input logic [31:0] sw, input logic [7:0] ty, input logic [15:0] len);
    for (int i = 3; i >= 0; i--) send_byte(sw[8*i +: 8]);
    send_byte(ty);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_frame(input logic [31:0] sw, input logic [7:0] ty, input logic [15:0] len,
                            input int body);
    send_header(sw, ty, len);
    for (int i = 0; i < body; i++) send_byte(pick_byte());
  endtask

  // Filler until the parser hunts for sync on a group boundary
  task automatic resync();
    while (!(sb.stage == ST_HUNT && sb.sync_cnt == 2'd0)) send_byte(pick_byte());
  endtask

  task automatic random_settings();
    logic [31:0] sw;
    logic [7:0]  ft;
    logic [7:0]  st;
    logic [15:0] ml;
    case ($urandom_range(5))
      0: sw = 32'h0000_0000;
      1: sw = 32'hFFFF_FFFF;
      default: sw = $urandom;
    endcase
    ft = 8'($urandom_range(255));
    st = ($urandom_range(3) == 0) ? ft : 8'($urandom_range(255));
    case ($urandom_range(9))
      0: ml = 16'd0;
      1: ml = 16'hFFFF;
      default: ml = 16'($urandom_range(1, 16));
    endcase
    set_regs(sw, ft, st, ml);
  endtask

  // Mostly well-formed frames, with noise, corrupted sync and cut-short frames
  task automatic run_traffic(input int n);
    int          stop;
    int          pick;
    logic [7:0]  ty;
    logic [15:0] len;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: ty = sb.first_type;
        1: ty = sb.second_type;
        default: ty = 8'($urandom_range(255));
      endcase
      len = 16'($urandom_range(1, 12));
      if (pick < 70) begin
        resync();
        case ($urandom_range(6))
          0: len = 16'd0;
          1: if (sb.max_len < 16'd65530) len = sb.max_len + 16'($urandom_range(1, 6));
          default: ;
        endcase
        send_frame(sb.sync_word, ty, len, len);
      end else if (pick < 80) begin
        repeat (4 * $urandom_range(1, 2)) send_byte(pick_byte());
      end else if (pick < 88) begin
        resync();
        send_frame(sb.sync_word ^ (32'h1 << $urandom_range(31)), ty, len, len);
      end else if (pick < 96) begin
        resync();
        send_frame(sb.sync_word, ty, len, $urandom_range(0, len - 1));
      end else begin
        drain_results();
      end
    end
  endtask

  // Stimulus
  initial begin
    int idle_plan[3][2];
    idle_plan = '{'{21, 62}, '{62, 21}, '{0, 0}};
    rx_ch.valid  = 1'b0;
    rx_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: routes, byte extremes, empty, sync mismatch, oversize skip
    src_idle  = 21;
    sink_idle = 62;
    send_header(SYNC_WORD_RST, FIRST_TYPE_RST, 16'd1);
    send_byte(8'h00);
    send_header(SYNC_WORD_RST, SECOND_TYPE_RST, 16'd2);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_header(SYNC_WORD_RST, 8'hFF, 16'd0);
    repeat (4) send_byte(8'hFF);
    repeat (4) send_byte(8'h00);
    send_frame(SYNC_WORD_RST, 8'h00, MAX_LEN_RST + 16'd1, MAX_LEN_RST + 1);

    // register change in mid-frame; both route types equal
    send_header(SYNC_WORD_RST, 8'h33, 16'd3);
    set_regs(SYNC_WORD_RST, 8'h33, 8'h33, MAX_LEN_RST);
    repeat (3) send_byte(pick_byte());

    // maximum lowered before the length completes
    for (int i = 3; i >= 0; i--) send_byte(SYNC_WORD_RST[8*i +: 8]);
    send_byte(8'h33);
    send_byte(8'h00);
    set_regs(SYNC_WORD_RST, 8'h33, 8'h44, 16'd4);
    send_byte(8'h05);
    repeat (5) send_byte(pick_byte());

    // register extremes
    set_regs(32'h0000_0000, 8'h00, 8'hFF, 16'h0000);
    send_frame(32'h0000_0000, 8'hFF, 16'd1, 1);
    send_frame(32'h0000_0000, 8'h00, 16'd0, 0);
    set_regs(32'hFFFF_FFFF, 8'hFF, 8'h00, 16'hFFFF);
    send_frame(32'hFFFF_FFFF, 8'h00, 16'd3, 3);
    send_header(SYNC_WORD_RST, 8'hFF, 16'd0);
    resync();
    send_frame(32'hFFFF_FFFF, 8'h7E, 16'h0102, 258);

    // random traffic under three idle patterns
    for (int p = 0; p < 3; p++) begin
      src_idle  = idle_plan[p][0];
      sink_idle = idle_plan[p][1];
      for (int k = 0; k < 3; k++) begin
        random_settings();
        run_traffic(50);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected results never came", sb.pending()));

    $display("Sent %0d stream bytes under %0d register settings, checked %0d results",
             bytes_sent, settings_applied, sb.checked);
    $display("  payload %0d, empty frame %0d, sync mismatch %0d, oversize %0d",
             sb.kind_seen[KIND_PAYLOAD], sb.kind_seen[KIND_EMPTY],
             sb.kind_seen[KIND_SYNC_ERR], sb.kind_seen[KIND_OVERSIZE]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
